// ===== design/tleb_pkg.sv =====
// Shared constants, codes, types and helpers of the terminal line edit buffer.
package tleb_pkg;

    localparam int LINE_CAPACITY = 255;
    localparam int PTR_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int KEY_W         = 8;
    localparam int OUT_W         = 8;
    localparam int CMP_W         = (PTR_W > KEY_W) ? PTR_W : KEY_W;

    localparam logic [1:0] FILTER_ANY      = 2'd0;
    localparam logic [1:0] FILTER_ALNUM    = 2'd1;
    localparam logic [1:0] FILTER_NO_SPACE = 2'd2;

    localparam logic [KEY_W-1:0] CH_DIGIT_LO = 8'h30;
    localparam logic [KEY_W-1:0] CH_DIGIT_HI = 8'h39;
    localparam logic [KEY_W-1:0] CH_LOWER_LO = 8'h61;
    localparam logic [KEY_W-1:0] CH_LOWER_HI = 8'h7a;
    localparam logic [KEY_W-1:0] CH_UPPER_LO = 8'h41;
    localparam logic [KEY_W-1:0] CH_UPPER_HI = 8'h5a;
    localparam logic [KEY_W-1:0] CH_SPACE    = 8'h20;

    typedef enum logic [3:0] {
        KEY_CHAR      = 4'd0,
        KEY_HOME      = 4'd1,
        KEY_LEFT      = 4'd2,
        KEY_END       = 4'd3,
        KEY_RIGHT     = 4'd4,
        KEY_BKSP      = 4'd5,
        KEY_KILL_END  = 4'd6,
        KEY_FF        = 4'd7,
        KEY_CR        = 4'd8,
        KEY_HIST_DOWN = 4'd9,
        KEY_HIST_UP   = 4'd10,
        KEY_KILL_LINE = 4'd11,
        KEY_TAB       = 4'd12,
        KEY_NOP       = 4'd13,
        KEY_CLEAR     = 4'd14,
        KEY_READ      = 4'd15
    } t_key_cmd;

    typedef enum logic [2:0] {
        EV_NONE           = 3'd0,
        EV_CLEAR_SCREEN   = 3'd1,
        EV_EXECUTE        = 3'd2,
        EV_HIST_DOWN      = 3'd3,
        EV_HIST_UP        = 3'd4,
        EV_COMPLETE_FIRST = 3'd5,
        EV_COMPLETE_AGAIN = 3'd6
    } t_line_event;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HOME,
        OP_LEFT,
        OP_END,
        OP_RIGHT,
        OP_KILL_END,
        OP_CLEAR,
        OP_GROW,
        OP_SHRINK
    } t_reg_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        load_req;
        t_reg_op     reg_op;
        logic        tab_set;
        logic        tab_clr;
        logic        ev_load;
        t_line_event ev;
        logic        rd_req;
        logic        ptr_from_len;
        logic        ptr_from_cur;
        logic        shift_up;
        logic        shift_dn;
        logic        wr_char;
        logic        out_load;
    } t_dp_ctrl;

    typedef struct packed {
        t_key_cmd cmd;
        logic     in_tab;
        logic     char_ok;
        logic     full;
        logic     cur_zero;
        logic     cur_at_len;
        logic     ptr_at_cur;
        logic     ptr_at_len;
        logic     pend;
        logic     idx_hit;
    } t_dp_stat;

    function automatic logic char_ok(input logic [1:0] mode, input logic [KEY_W-1:0] c);
        logic ok;
        unique case (mode)
            FILTER_ALNUM: begin
                ok = (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
                     (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
                     (c >= CH_UPPER_LO && c <= CH_UPPER_HI);
            end
            FILTER_NO_SPACE: begin
                ok = (c != CH_SPACE);
            end
            default: begin
                ok = 1'b1;
            end
        endcase
        return ok;
    endfunction

endpackage

// ===== design/tleb_datapath.sv =====
// Datapath: line memory, cursor and length registers, shift pointer and result register.
module tleb_datapath
    import tleb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_mode,
    input  logic [3:0]          i_cmd,
    input  logic [KEY_W-1:0]    i_key_char,
    input  logic [KEY_W-1:0]    i_read_index,
    input  t_dp_ctrl            i_ctrl,
    output t_dp_stat            o_stat,
    output logic [2:0]          o_line_event,
    output logic [OUT_W-1:0]    o_cursor_pos,
    output logic [OUT_W-1:0]    o_line_length,
    output logic [OUT_W-1:0]    o_read_data
);

    logic [KEY_W-1:0]  r_line [LINE_CAPACITY];
    logic [KEY_W-1:0]  r_mem_q;

    t_key_cmd          r_cmd;
    logic [KEY_W-1:0]  r_char;
    logic [KEY_W-1:0]  r_idx;

    logic [PTR_W-1:0]  r_cursor;
    logic [PTR_W-1:0]  r_length;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_in_tab;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    logic              r_rd_hit;
    t_line_event       r_event;

    logic [2:0]        r_out_event;
    logic [OUT_W-1:0]  r_out_cursor;
    logic [OUT_W-1:0]  r_out_length;
    logic [OUT_W-1:0]  r_out_data;

    logic [PTR_W-1:0]  w_ptr_dec;
    logic [CMP_W-1:0]  w_idx_ext;
    logic [CMP_W-1:0]  w_len_ext;
    logic [CMP_W-1:0]  w_cur_ext;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_rd_en;

    assign w_ptr_dec = r_ptr - PTR_W'(1);
    assign w_idx_ext = CMP_W'(r_idx);
    assign w_len_ext = CMP_W'(r_length);
    assign w_cur_ext = CMP_W'(r_cursor);

    // status toward the controller
    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.in_tab     = r_in_tab;
        o_stat.char_ok    = char_ok(i_mode, r_char);
        o_stat.full       = (r_length == PTR_W'(LINE_CAPACITY));
        o_stat.cur_zero   = (r_cursor == '0);
        o_stat.cur_at_len = (r_cursor == r_length);
        o_stat.ptr_at_cur = (r_ptr == r_cursor);
        o_stat.ptr_at_len = (r_ptr == r_length);
        o_stat.pend       = r_pend;
        o_stat.idx_hit    = (w_idx_ext < w_len_ext);
    end

    // held request fields
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_req) begin
            r_cmd  <= t_key_cmd'(i_cmd);
            r_char <= i_key_char;
            r_idx  <= i_read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_length <= '0;
        end else begin
            unique case (i_ctrl.reg_op)
                OP_NONE: begin
                end
                OP_HOME: begin
                    r_cursor <= '0;
                end
                OP_LEFT: begin
                    if (r_cursor != '0) begin
                        r_cursor <= r_cursor - PTR_W'(1);
                    end
                end
                OP_END: begin
                    r_cursor <= r_length;
                end
                OP_RIGHT: begin
                    if (r_cursor != r_length) begin
                        r_cursor <= r_cursor + PTR_W'(1);
                    end
                end
                OP_KILL_END: begin
                    r_length <= r_cursor;
                end
                OP_CLEAR: begin
                    r_cursor <= '0;
                    r_length <= '0;
                end
                OP_GROW: begin
                    r_cursor <= r_cursor + PTR_W'(1);
                    r_length <= r_length + PTR_W'(1);
                end
                OP_SHRINK: begin
                    r_cursor <= r_cursor - PTR_W'(1);
                    r_length <= r_length - PTR_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_pend_addr <= '0;
            r_in_tab    <= 1'b0;
            r_rd_hit    <= 1'b0;
            r_event     <= EV_NONE;
        end else begin
            if (i_ctrl.ptr_from_len) begin
                r_ptr <= r_length;
            end else if (i_ctrl.ptr_from_cur) begin
                r_ptr <= r_cursor;
            end else if (i_ctrl.shift_up) begin
                r_ptr <= w_ptr_dec;
            end else if (i_ctrl.shift_dn) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end
            // a shift read lands in the following cycle as a write one slot away
            r_pend <= i_ctrl.shift_up | i_ctrl.shift_dn;
            if (i_ctrl.shift_up) begin
                r_pend_addr <= r_ptr[ADDR_W-1:0];
            end else if (i_ctrl.shift_dn) begin
                r_pend_addr <= w_ptr_dec[ADDR_W-1:0];
            end
            if (i_ctrl.tab_set) begin
                r_in_tab <= 1'b1;
            end else if (i_ctrl.tab_clr) begin
                r_in_tab <= 1'b0;
            end
            if (i_ctrl.ev_load) begin
                r_event  <= i_ctrl.ev;
                r_rd_hit <= i_ctrl.rd_req;
            end
        end
    end

    // memory read port
    always_comb begin
        w_rd_en = i_ctrl.rd_req | i_ctrl.shift_up | i_ctrl.shift_dn;
        if (i_ctrl.rd_req) begin
            w_rd_addr = w_idx_ext[ADDR_W-1:0];
        end else if (i_ctrl.shift_up) begin
            w_rd_addr = w_ptr_dec[ADDR_W-1:0];
        end else begin
            w_rd_addr = r_ptr[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_mem_q <= r_line[w_rd_addr];
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_line[r_pend_addr] <= r_mem_q;
        end else if (i_ctrl.wr_char) begin
            r_line[r_cursor[ADDR_W-1:0]] <= r_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_event  <= r_event;
            r_out_cursor <= w_cur_ext[OUT_W-1:0];
            r_out_length <= w_len_ext[OUT_W-1:0];
            r_out_data   <= r_rd_hit ? r_mem_q : '0;
        end
    end

    assign o_line_event  = r_out_event;
    assign o_cursor_pos  = r_out_cursor;
    assign o_line_length = r_out_length;
    assign o_read_data   = r_out_data;

endmodule

// ===== design/tleb_ctrl.sv =====
// Controller: sequences each request through decode, buffer shifts and result hand-off.
module tleb_ctrl
    import tleb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_ctrl      = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load_req = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.ev_load = 1'b1;
                n_state        = S_DONE;
                if (i_stat.cmd == KEY_CLEAR) begin
                    o_ctrl.reg_op = OP_CLEAR;
                end else if (i_stat.cmd == KEY_READ) begin
                    o_ctrl.rd_req = i_stat.idx_hit;
                end else if (i_stat.in_tab && i_stat.cmd == KEY_TAB) begin
                    o_ctrl.ev = EV_COMPLETE_AGAIN;
                end else begin
                    o_ctrl.tab_clr = 1'b1;
                    unique case (i_stat.cmd)
                        KEY_CHAR: begin
                            if (i_stat.char_ok && !i_stat.full) begin
                                if (i_stat.cur_at_len) begin
                                    o_ctrl.wr_char = 1'b1;
                                    o_ctrl.reg_op  = OP_GROW;
                                end else begin
                                    o_ctrl.ptr_from_len = 1'b1;
                                    n_state             = S_SHIFT_UP;
                                end
                            end
                        end
                        KEY_HOME:      o_ctrl.reg_op = OP_HOME;
                        KEY_LEFT:      o_ctrl.reg_op = OP_LEFT;
                        KEY_END:       o_ctrl.reg_op = OP_END;
                        KEY_RIGHT:     o_ctrl.reg_op = OP_RIGHT;
                        KEY_BKSP: begin
                            if (!i_stat.cur_zero) begin
                                o_ctrl.ptr_from_cur = 1'b1;
                                n_state             = S_SHIFT_DN;
                            end
                        end
                        KEY_KILL_END:  o_ctrl.reg_op = OP_KILL_END;
                        KEY_FF:        o_ctrl.ev = EV_CLEAR_SCREEN;
                        KEY_CR:        o_ctrl.ev = EV_EXECUTE;
                        KEY_HIST_DOWN: o_ctrl.ev = EV_HIST_DOWN;
                        KEY_HIST_UP:   o_ctrl.ev = EV_HIST_UP;
                        KEY_KILL_LINE: o_ctrl.reg_op = OP_CLEAR;
                        KEY_TAB: begin
                            o_ctrl.ev      = EV_COMPLETE_FIRST;
                            o_ctrl.tab_set = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                if (!i_stat.ptr_at_cur) begin
                    o_ctrl.shift_up = 1'b1;
                end else if (!i_stat.pend) begin
                    o_ctrl.wr_char = 1'b1;
                    o_ctrl.reg_op  = OP_GROW;
                    n_state        = S_DONE;
                end
            end
            S_SHIFT_DN: begin
                if (!i_stat.ptr_at_len) begin
                    o_ctrl.shift_dn = 1'b1;
                end else if (!i_stat.pend) begin
                    o_ctrl.reg_op = OP_SHRINK;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.out_load = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/terminal_line_edit_buffer.sv =====
// Top level of the terminal line edit buffer: configuration port, controller and datapath.
//
// Each request carries one decoded key symbol and produces exactly one result with the
// line event, the cursor position, the line length and, for a read-back request, the stored
// character. Requests are handled one at a time. A request that does not move stored
// characters passes through accept, decode and hand-off to a loaded result. An insert inside
// the line or a backspace first moves each character behind the cursor by one slot: the
// line sits in a memory with one read port and one write port, so characters move one at
// a time, and the last moved character lands before the registers update. Inserts at the
// end of the line need no shift. The hand-off waits while the previous result still sits
// unclaimed in the result register. The next request is taken as soon as the result
// register is loaded, even while that result still waits on the output side. The input
// mode register lies at byte address 0 of the configuration port and is to be written
// by the user only while the block is idle; the block itself does not enforce this.
module terminal_line_edit_buffer
    import tleb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // key request channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [3:0]       i_cmd,
    input  logic [KEY_W-1:0] i_key_char,
    input  logic [KEY_W-1:0] i_read_index,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_line_event,
    output logic [OUT_W-1:0] o_cursor_pos,
    output logic [OUT_W-1:0] o_line_length,
    output logic [OUT_W-1:0] o_read_data
);

    logic [1:0] r_mode;
    t_dp_ctrl   w_ctrl;
    t_dp_stat   w_stat;

    // Hold the input mode; write it on the access phase of a register write.
    // Address bit 2 selects beyond the single register, so those writes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= FILTER_ANY;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {30'd0, r_mode};

    // Sequence each request: decode, shift the line, then hand off the result.
    tleb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    // Line memory, cursor, length, tab state and the result register.
    tleb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_mode),
        .i_cmd         (i_cmd),
        .i_key_char    (i_key_char),
        .i_read_index  (i_read_index),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .o_line_event  (o_line_event),
        .o_cursor_pos  (o_cursor_pos),
        .o_line_length (o_line_length),
        .o_read_data   (o_read_data)
    );

endmodule

// ===== tb/tb_terminal_line_edit_buffer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the terminal line edit buffer: key requests in, line state out.
module tb_terminal_line_edit_buffer
    import tleb_pkg::*;
;

    // Configuration register map and the mode code that the block treats as session mode.
    localparam logic [2:0] REG_INPUT_MODE = 3'd0;
    localparam logic [1:0] MODE_SPARE     = 2'd3;

    // Idling and pacing.
    localparam int GAP_MAX        = 18;
    localparam int LONG_HOLD      = 250;  // receiver hold-off that backs the block up
    localparam int HOLD_AT_FIRST  = 80;   // result counts after which the long hold-off starts
    localparam int HOLD_AT_SECOND = 400;
    localparam int QUIET_LIMIT    = 4000; // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES   = 300;  // long enough to cover a full-line shift
    localparam int CFG_SETTLE     = 4;
    localparam int PHASE_KEYS     = 40;

    typedef struct {
        t_key_cmd         cmd;
        logic [KEY_W-1:0] ch;
        logic [KEY_W-1:0] idx;
        int               gap;    // idle cycles after this request is taken
        bit               drain;  // hold this request until every result has come back
    } t_key_req;

    typedef struct {
        t_line_event      ev;
        logic [OUT_W-1:0] cursor;
        logic [OUT_W-1:0] len;
        logic [OUT_W-1:0] rd;
    } t_edit_result;

    // Block ports; every input starts at a known value.
    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [2:0]       paddr        = '0;
    logic [31:0]      pwdata       = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    logic [3:0]       i_cmd        = '0;
    logic [KEY_W-1:0] i_key_char   = '0;
    logic [KEY_W-1:0] i_read_index = '0;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    logic [2:0]       o_line_event;
    logic [OUT_W-1:0] o_cursor_pos;
    logic [OUT_W-1:0] o_line_length;
    logic [OUT_W-1:0] o_read_data;

    // Our own copy of the line, cursor, tab state and input mode.
    logic [KEY_W-1:0] line_copy [LINE_CAPACITY];
    int               cursor_copy = 0;
    int               length_copy = 0;
    bit               tab_armed   = 1'b0;
    logic [1:0]       mode_copy   = FILTER_ANY;

    t_key_req     pending_keys[$];
    t_edit_result results_due[$];
    t_key_req     in_flight;
    t_edit_result rx_want;
    int           queued_total   = 0;
    int           accepted_total = 0;
    int           rx_count       = 0;
    int           fail_count     = 0;
    int           send_wait      = 0;
    int           rx_stall       = 0;

    always #1 i_clk = ~i_clk;

    terminal_line_edit_buffer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_key_char   (i_key_char),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_event (o_line_event),
        .o_cursor_pos (o_cursor_pos),
        .o_line_length(o_line_length),
        .o_read_data  (o_read_data)
    );

    // ------------------------------------------------------------------
    // Line editor prediction
    // ------------------------------------------------------------------

    // Mode filter on inserted characters; the spare mode code acts as session mode.
    function automatic bit key_allowed(input logic [KEY_W-1:0] c);
        case (mode_copy)
            FILTER_ALNUM: begin
                return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) ||
                       (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
                       (c >= CH_UPPER_LO && c <= CH_UPPER_HI);
            end
            FILTER_NO_SPACE: begin
                return c != CH_SPACE;
            end
            default: begin
                return 1'b1;
            end
        endcase
    endfunction

    // Apply one accepted request to the line copy and queue the result it must produce.
    function automatic void apply_key(input t_key_req k);
        t_edit_result r;
        r.ev = EV_NONE;
        r.rd = '0;
        if (k.cmd == KEY_CLEAR) begin
            // clear and read-back leave the tab state alone
            cursor_copy = 0;
            length_copy = 0;
        end else if (k.cmd == KEY_READ) begin
            if (int'(k.idx) < length_copy) r.rd = line_copy[k.idx];
        end else if (tab_armed && k.cmd == KEY_TAB) begin
            r.ev = EV_COMPLETE_AGAIN;
        end else begin
            // any other key drops the tab state, then acts as from idle
            tab_armed = 1'b0;
            case (k.cmd)
                KEY_CHAR: begin
                    if (key_allowed(k.ch) && length_copy < LINE_CAPACITY) begin
                        for (int i = length_copy; i > cursor_copy; i--)
                            line_copy[i] = line_copy[i-1];
                        line_copy[cursor_copy] = k.ch;
                        length_copy++;
                        cursor_copy++;
                    end
                end
                KEY_HOME:  cursor_copy = 0;
                KEY_LEFT:  if (cursor_copy > 0) cursor_copy--;
                KEY_END:   cursor_copy = length_copy;
                KEY_RIGHT: if (cursor_copy < length_copy) cursor_copy++;
                KEY_BKSP: begin
                    if (cursor_copy > 0) begin
                        for (int i = cursor_copy; i < length_copy; i++)
                            line_copy[i-1] = line_copy[i];
                        cursor_copy--;
                        length_copy--;
                    end
                end
                KEY_KILL_END:  length_copy = cursor_copy;
                KEY_FF:        r.ev = EV_CLEAR_SCREEN;
                KEY_CR:        r.ev = EV_EXECUTE;
                KEY_HIST_DOWN: r.ev = EV_HIST_DOWN;
                KEY_HIST_UP:   r.ev = EV_HIST_UP;
                KEY_KILL_LINE: begin
                    cursor_copy = 0;
                    length_copy = 0;
                end
                KEY_TAB: begin
                    r.ev      = EV_COMPLETE_FIRST;
                    tab_armed = 1'b1;
                end
                default: ;
            endcase
        end
        r.cursor = OUT_W'(cursor_copy);
        r.len    = OUT_W'(length_copy);
        results_due.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want_v,
                                          input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer the queued requests, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_key(in_flight);
                accepted_total++;
                send_wait = in_flight.gap;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold valid and payload until the block takes the request
            end else if (send_wait > 0) begin
                send_wait--;
                i_in_valid <= 1'b0;
            end else if (pending_keys.size() != 0 &&
                         !(pending_keys[0].drain && results_due.size() != 0)) begin
                in_flight = pending_keys.pop_front();
                i_cmd        <= in_flight.cmd;
                i_key_char   <= in_flight.ch;
                i_read_index <= in_flight.idx;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stall at random, check every result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing pending: event %0d cursor %0d",
                             $time, o_line_event, o_cursor_pos);
                    $display("%0t: unexpected result continued: length %0d data %0d",
                             $time, o_line_length, o_read_data);
                    fail_count++;
                end else begin
                    rx_want = results_due.pop_front();
                    compare_field("line_event", 8'(rx_want.ev), 8'(o_line_event));
                    compare_field("cursor_pos", rx_want.cursor, o_cursor_pos);
                    compare_field("line_length", rx_want.len, o_line_length);
                    compare_field("read_data", rx_want.rd, o_read_data);
                end
                rx_count++;
                // long hold-off twice, a calm stretch every third block of 40, else random
                if (rx_count == HOLD_AT_FIRST || rx_count == HOLD_AT_SECOND)
                    rx_stall = LONG_HOLD;
                else if ((rx_count / 40) % 3 == 2)
                    rx_stall = 0;
                else
                    rx_stall = $urandom_range(0, GAP_MAX);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when no handshake happens for too long
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[terminal_line_edit_buffer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Drop the sender gap to zero for every fourth block of 40 requests.
    function automatic int draw_gap();
        if ((queued_total / 40) % 4 == 3) return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic void queue_key(input t_key_cmd cmd, input logic [KEY_W-1:0] ch = '0,
                                      input logic [KEY_W-1:0] idx = '0, input bit drain = 1'b0);
        t_key_req k;
        k.cmd   = cmd;
        k.ch    = ch;
        k.idx   = idx;
        k.gap   = draw_gap();
        k.drain = drain;
        pending_keys.push_back(k);
        queued_total++;
    endfunction

    // Half the characters sit on a boundary of the mode filters.
    function automatic logic [KEY_W-1:0] random_char();
        logic [KEY_W-1:0] border [15];
        border = '{8'h00, 8'h20, 8'h2f, 8'h30, 8'h39, 8'h3a, 8'h40, 8'h41,
                   8'h5a, 8'h5b, 8'h60, 8'h61, 8'h7a, 8'h7b, 8'hff};
        if ($urandom_range(0, 1) == 1) return border[$urandom_range(0, 14)];
        return KEY_W'($urandom_range(0, 255));
    endfunction

    // Typing-heavy mix of editing keys, with events, tabs and read-backs sprinkled in.
    function automatic void queue_random_key(input bit drain);
        int               pick;
        t_key_cmd         cmd;
        logic [KEY_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 40)      cmd = KEY_CHAR;
        else if (pick < 62) cmd = t_key_cmd'(4'($urandom_range(int'(KEY_HOME), int'(KEY_RIGHT))));
        else if (pick < 72) cmd = KEY_BKSP;
        else if (pick < 80) cmd = t_key_cmd'(4'($urandom_range(int'(KEY_FF), int'(KEY_HIST_UP))));
        else if (pick < 87) cmd = KEY_TAB;
        else if (pick < 97) cmd = KEY_READ;
        else begin
            case ($urandom_range(0, 3))
                0:       cmd = KEY_KILL_END;
                1:       cmd = KEY_KILL_LINE;
                2:       cmd = KEY_NOP;
                default: cmd = KEY_CLEAR;
            endcase
        end
        idx = ($urandom_range(0, 9) < 7) ? KEY_W'($urandom_range(0, 31))
                                         : KEY_W'($urandom_range(0, 254));
        queue_key(cmd, random_char(), idx, drain);
    endfunction

    // Wait until every request is taken and every result is back.
    task automatic wait_idle();
        while (accepted_total != queued_total || results_due.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the end of access.
    task automatic write_mode(input logic [1:0] mode);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_INPUT_MODE;
        pwdata  <= {30'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        mode_copy = mode;
    endtask

    initial begin
        logic [1:0] phase_modes [4];
        phase_modes = '{FILTER_ALNUM, FILTER_NO_SPACE, MODE_SPARE, FILTER_ANY};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, session mode from reset: limits of the cursor on an empty line,
        // byte extremes, an insert inside the line, tab sequences and every event.
        queue_key(KEY_READ, '0, 8'd0);
        queue_key(KEY_READ, '0, 8'd254);
        queue_key(KEY_LEFT);
        queue_key(KEY_BKSP);
        queue_key(KEY_RIGHT);
        queue_key(KEY_CHAR, 8'h00);
        queue_key(KEY_CHAR, 8'hff);
        queue_key(KEY_CHAR, 8'h61);
        queue_key(KEY_CHAR, CH_SPACE);
        queue_key(KEY_HOME);
        queue_key(KEY_RIGHT);
        queue_key(KEY_CHAR, 8'h5a);
        queue_key(KEY_LEFT);
        queue_key(KEY_END);
        queue_key(KEY_BKSP);
        queue_key(KEY_LEFT);
        queue_key(KEY_KILL_END);
        queue_key(KEY_READ, '0, 8'd2);
        queue_key(KEY_READ, '0, 8'd3);   // right at the line end
        queue_key(KEY_TAB);
        queue_key(KEY_TAB);
        queue_key(KEY_CLEAR);            // tab state survives a clear
        queue_key(KEY_TAB);
        queue_key(KEY_NOP);              // but not a no-op key
        queue_key(KEY_TAB);
        queue_key(KEY_CHAR, 8'h71);
        queue_key(KEY_FF);
        queue_key(KEY_CR);
        queue_key(KEY_HIST_DOWN);
        queue_key(KEY_HIST_UP);
        queue_key(KEY_KILL_LINE);

        // Random phases, one per input mode; pause the sender once per phase until drained.
        foreach (phase_modes[p]) begin
            wait_idle();
            write_mode(phase_modes[p]);
            for (int n = 0; n < PHASE_KEYS; n++) queue_random_key(n == PHASE_KEYS / 2);
        end

        // Fill the line to capacity, then push on a full line and shift across all of it.
        wait_idle();
        write_mode(FILTER_ANY);
        queue_key(KEY_KILL_LINE);
        repeat (LINE_CAPACITY) queue_key(KEY_CHAR, KEY_W'($urandom_range(0, 255)));
        queue_key(KEY_CHAR, random_char());
        queue_key(KEY_HOME);
        queue_key(KEY_CHAR, random_char());
        queue_key(KEY_READ, '0, 8'd0);
        queue_key(KEY_READ, '0, 8'd254);
        queue_key(KEY_END);
        queue_key(KEY_BKSP);
        queue_key(KEY_HOME);
        queue_key(KEY_CHAR, random_char());
        queue_key(KEY_CHAR, random_char());
        queue_key(KEY_READ, '0, 8'd254);
        queue_key(KEY_READ, '0, 8'd0);
        queue_key(KEY_RIGHT);
        queue_key(KEY_BKSP);
        queue_key(KEY_READ, '0, 8'd1);
        queue_key(KEY_CLEAR);

        // Back to the tightest filter for a last random stretch.
        wait_idle();
        write_mode(FILTER_ALNUM);
        for (int n = 0; n < 40; n++) queue_random_key(n == 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("[terminal_line_edit_buffer] OK");
        else
            $display("[terminal_line_edit_buffer] ERROR");
        $finish;
    end

endmodule
